// ===== design/ssd_pkg.sv =====
package ssd_pkg;

  // Command codes carried on the cmd field.
  typedef enum logic [1:0] {
    CMD_NUMBER  = 2'd0,
    CMD_TEXT    = 2'd1,
    CMD_REFRESH = 2'd2
  } cmd_e;

  localparam int unsigned NumDigits = 4;
  localparam int unsigned FrameBits = 16;

  // Active-low segment patterns.
  localparam logic [7:0] SegUnknown    = 8'd182;
  localparam logic [7:0] SegBlank      = 8'hFF;
  localparam logic [7:0] SegMinus      = 8'hBF;
  localparam logic [7:0] SegDot        = 8'd127;
  localparam logic [7:0] SegUnderscore = 8'd247;
  localparam logic [7:0] SegLetterE    = 8'd134;

  // Range of integers that fit in four places.
  localparam logic signed [15:0] NumMin = -16'sd999;
  localparam logic signed [15:0] NumMax = 16'sd9999;

  // Reciprocal of 100 as a 19-bit fraction; exact for magnitudes up to 9999.
  localparam logic [12:0] Recip100 = 13'd5243;
  localparam int unsigned Recip100Shift = 19;

  localparam logic [7:0] DigitMap [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  localparam logic [7:0] LetterMap [26] = '{
    8'd136, 8'd131, 8'd167, 8'd161, 8'd134, 8'd142, 8'd144, 8'd139, 8'd207,
    8'd241, 8'd182, 8'd199, 8'd182, 8'd171, 8'd163, 8'd140, 8'd152, 8'd175,
    8'd146, 8'd135, 8'd227, 8'd182, 8'd182, 8'd182, 8'd145, 8'd182
  };

  localparam logic [7:0] SelectMap [4] = '{8'hF1, 8'hF2, 8'hF4, 8'hF8};

  // Raw input beat.
  typedef struct packed {
    logic [1:0]        cmd;
    logic signed [15:0] number;
    logic [3:0][7:0]   chars;
  } raw_t;

  // Item after the first stage: the integer is range-checked and split by 100.
  typedef struct packed {
    logic [1:0]      cmd;
    logic            neg;
    logic            in_range;
    logic [13:0]     mag;
    logic [6:0]      hi;
    logic [3:0][7:0] chars;
  } split_t;

  // Pattern for a decimal digit 0..9.
  function automatic logic [7:0] digit_pattern(input logic [3:0] d);
    logic [7:0] p;
    if (d <= 4'd9) begin
      p = DigitMap[d];
    end else begin
      p = SegUnknown;
    end
    return p;
  endfunction

  // Pattern for an ASCII code; upper case letters fold to lower case.
  function automatic logic [7:0] char_pattern(input logic [7:0] c);
    logic [7:0] lc;
    logic [4:0] li;
    logic [7:0] p;
    lc = (c inside {[8'h41:8'h5A]}) ? c + 8'd32 : c;
    li = lc[4:0] - 5'd1;
    if (lc inside {[8'h30:8'h39]}) begin
      p = DigitMap[lc[3:0]];
    end else if (lc inside {[8'h61:8'h7A]}) begin
      p = LetterMap[li];
    end else if (lc == 8'h2D) begin
      p = SegMinus;
    end else if (lc == 8'h2E) begin
      p = SegDot;
    end else if (lc == 8'h5F) begin
      p = SegUnderscore;
    end else if (lc == 8'h20) begin
      p = SegBlank;
    end else begin
      p = SegUnknown;
    end
    return p;
  endfunction

  // Tens digit of a value 0..99, by nine parallel compares.
  function automatic logic [3:0] tens_of(input logic [6:0] x);
    logic [3:0] t;
    t = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (x >= 7'(k * 10)) begin
        t = t + 4'd1;
      end
    end
    return t;
  endfunction

endpackage

// ===== design/ssd_split.sv =====
module ssd_split
  import ssd_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  raw_t   raw_i,
  output logic   valid_o,
  input  logic   ready_i,
  output split_t split_o
);

  logic         valid_q;
  split_t       split_q, split_d;
  logic [15:0]  abs_val;
  logic [26:0]  prod;

  // Range check, magnitude and one multiply by the reciprocal of 100.
  always_comb begin
    abs_val           = raw_i.number[15] ? 16'(-raw_i.number) : raw_i.number;
    prod              = 27'(abs_val[13:0]) * 27'(Recip100);
    split_d.cmd       = raw_i.cmd;
    split_d.neg       = raw_i.number[15];
    split_d.in_range  = (raw_i.number >= NumMin) && (raw_i.number <= NumMax);
    split_d.mag       = abs_val[13:0];
    split_d.hi        = prod[Recip100Shift +: 7];
    split_d.chars     = raw_i.chars;
  end

  assign ready_o = !valid_q || ready_i;

  // Stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      split_q <= split_d;
    end
  end

  assign valid_o = valid_q;
  assign split_o = split_q;

endmodule

// ===== design/ssd_store.sv =====
module ssd_store
  import ssd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  split_t      split_i,
  output logic        load_valid_o,
  input  logic        load_ready_i,
  output logic [15:0] load_word_o,
  output logic [1:0]  load_digit_o
);

  logic [7:0]  patterns_q [NumDigits];
  logic [7:0]  num_pat [NumDigits];
  logic [7:0]  text_pat [NumDigits];
  logic [1:0]  ptr_q;
  logic [13:0] hi_x100;
  logic [6:0]  lo;
  logic [3:0]  th, hu, te, on;
  logic        ge10, ge100, ge1000;
  logic        is_refresh, fire, refresh_fire, number_fire, text_fire;

  // Second half of the decimal split and the four number patterns.
  always_comb begin
    hi_x100 = (14'(split_i.hi) << 6) + (14'(split_i.hi) << 5) + (14'(split_i.hi) << 2);
    lo      = 7'(split_i.mag - hi_x100);
    th      = tens_of(split_i.hi);
    hu      = 4'(split_i.hi - 7'(th) * 7'd10);
    te      = tens_of(lo);
    on      = 4'(lo - 7'(te) * 7'd10);
    ge10    = split_i.mag >= 14'd10;
    ge100   = split_i.mag >= 14'd100;
    ge1000  = split_i.mag >= 14'd1000;
    if (!split_i.in_range) begin
      num_pat[0] = SegBlank;
      num_pat[1] = SegBlank;
      num_pat[2] = SegBlank;
      num_pat[3] = SegLetterE;
    end else begin
      num_pat[3] = digit_pattern(on);
      num_pat[2] = ge10   ? digit_pattern(te) :
                   split_i.neg ? SegMinus : SegBlank;
      num_pat[1] = ge100  ? digit_pattern(hu) :
                   (split_i.neg && ge10) ? SegMinus : SegBlank;
      num_pat[0] = ge1000 ? digit_pattern(th) :
                   (split_i.neg && ge100) ? SegMinus : SegBlank;
    end
  end

  // Character patterns, leftmost first.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      text_pat[i] = char_pattern(split_i.chars[i]);
    end
  end

  // A refresh waits for the serializer; updates always go through.
  assign is_refresh   = split_i.cmd == CMD_REFRESH;
  assign ready_o      = !is_refresh || load_ready_i;
  assign fire         = valid_i && ready_o;
  assign refresh_fire = fire && is_refresh;
  assign number_fire  = fire && (split_i.cmd == CMD_NUMBER);
  assign text_fire    = fire && (split_i.cmd == CMD_TEXT);

  assign load_valid_o = valid_i && is_refresh;
  assign load_word_o  = {patterns_q[ptr_q], SelectMap[ptr_q]};
  assign load_digit_o = ptr_q;

  // Pattern store and refresh pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumDigits; i++) begin
        patterns_q[i] <= 8'h00;
      end
      ptr_q <= 2'd0;
    end else begin
      if (number_fire) begin
        patterns_q <= num_pat;
      end else if (text_fire) begin
        patterns_q <= text_pat;
      end
      if (refresh_fire) begin
        ptr_q <= ptr_q + 2'd1;
      end
    end
  end

  // The pointer moves by one on each refresh and holds otherwise.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    refresh_fire |=> ptr_q == $past(ptr_q) + 2'd1)
    else $error("refresh pointer did not advance");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !refresh_fire |=> $stable(ptr_q))
    else $error("refresh pointer moved without a refresh");
  // Patterns change only on an update command; checked on digits 0 and 3.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(number_fire || text_fire) |=> $stable(patterns_q[0]) && $stable(patterns_q[3]))
    else $error("digit pattern changed without an update");

endmodule

// ===== design/ssd_serializer.sv =====
module ssd_serializer
  import ssd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_valid_i,
  output logic        load_ready_o,
  input  logic [15:0] load_word_i,
  input  logic [1:0]  load_digit_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic        serial_data_o,
  output logic        latch_pulse_o,
  output logic [1:0]  digit_shown_o
);

  logic        valid_q;
  logic [3:0]  cnt_q;
  logic [15:0] word_q;
  logic [1:0]  digit_q;
  logic        last, beat, load;

  assign last         = cnt_q == 4'(FrameBits - 1);
  assign beat         = valid_q && ready_i;
  assign load_ready_o = !valid_q || (beat && last);
  assign load         = load_valid_i && load_ready_o;

  // Control: frame valid and bit counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= 4'd0;
    end else if (load) begin
      valid_q <= 1'b1;
      cnt_q   <= 4'd0;
    end else if (beat) begin
      valid_q <= !last;
      cnt_q   <= cnt_q + 4'd1;
    end
  end

  // Shift register, MSB goes out first.
  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q  <= load_word_i;
      digit_q <= load_digit_i;
    end else if (beat) begin
      word_q  <= {word_q[14:0], 1'b0};
    end
  end

  assign valid_o       = valid_q;
  assign serial_data_o = word_q[15];
  assign latch_pulse_o = last;
  assign digit_shown_o = digit_q;

  // A new frame starts at its first bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> valid_q && cnt_q == 4'd0)
    else $error("frame did not start at bit zero");
  // The frame ends after the latch beat unless another is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && last && !load_valid_i) |=> !valid_q)
    else $error("frame ran past the latch beat");
  // The digit index holds for the whole frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !(beat && last)) |=> $stable(digit_q))
    else $error("digit index changed inside a frame");

endmodule

// ===== design/seven_segment_display_driver_unit.sv =====
// Channel  Direction  Handshake                 Beat contents
// in       input      in_valid_i / in_ready_o   cmd_i, number_i, char_0_i .. char_3_i
// out      output     out_valid_o / out_ready_i serial_data_o, latch_pulse_o, digit_shown_o
//
// One input beat can be taken every cycle unless a refresh is held up ahead;
// an input register and a split stage lie between the input and the serializer,
// while the pattern store passes a refresh on combinationally. A refresh tick
// yields 16 output beats, one per cycle while out_ready_i is high; the single
// 16-bit serializer takes the next refresh only with its last beat. Updates
// wait only behind a refresh that is held up in front of them.
// Reset clears the four digit patterns to zero and the refresh pointer.
// A stalled output holds its bit; later refreshes wait in the stages before it.
module seven_segment_display_driver_unit
  import ssd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic signed [15:0] number_i,
  input  logic [7:0]  char_0_i,
  input  logic [7:0]  char_1_i,
  input  logic [7:0]  char_2_i,
  input  logic [7:0]  char_3_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        serial_data_o,
  output logic        latch_pulse_o,
  output logic [1:0]  digit_shown_o
);

  logic        a_valid_q;
  raw_t        a_q;
  logic        split_ready, split_valid;
  split_t      split;
  logic        store_ready;
  logic        load_valid, load_ready;
  logic [15:0] load_word;
  logic [1:0]  load_digit;

  assign in_ready_o = !a_valid_q || split_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_q.cmd    <= cmd_i;
      a_q.number <= number_i;
      a_q.chars  <= {char_3_i, char_2_i, char_1_i, char_0_i};
    end
  end

  ssd_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (a_valid_q),
    .ready_o (split_ready),
    .raw_i   (a_q),
    .valid_o (split_valid),
    .ready_i (store_ready),
    .split_o (split)
  );

  ssd_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (split_valid),
    .ready_o      (store_ready),
    .split_i      (split),
    .load_valid_o (load_valid),
    .load_ready_i (load_ready),
    .load_word_o  (load_word),
    .load_digit_o (load_digit)
  );

  ssd_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_valid_i  (load_valid),
    .load_ready_o  (load_ready),
    .load_word_i   (load_word),
    .load_digit_i  (load_digit),
    .valid_o       (out_valid_o),
    .ready_i       (out_ready_i),
    .serial_data_o (serial_data_o),
    .latch_pulse_o (latch_pulse_o),
    .digit_shown_o (digit_shown_o)
  );

endmodule
